// File: rtl/core/unix_time_to_local_civil_defines.svh
// assertion macros shared by the local civil time pipeline
// no dependencies; included by the modules that carry checks
`ifndef UNIX_TIME_TO_LOCAL_CIVIL_DEFINES_SVH
`define UNIX_TIME_TO_LOCAL_CIVIL_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication check
`define UTLC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utlc check failed in %m");

// next-cycle implication check
`define UTLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utlc check failed in %m");

`else

`define UTLC_ASSERT_IMPL(label, clk, rst, ante, cons)

`define UTLC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/utlc_pkg.sv
// shared types, register codes and division constants of the local civil time pipeline
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package utlc_pkg;

  // configuration register indexes
  typedef enum logic [1:0] {
    REG_BASE_EPOCH  = 2'd0,
    REG_UTC_OFFSET  = 2'd1,
    REG_BASE_MILLIS = 2'd2,
    REG_TIME_SET    = 2'd3
  } cfg_reg_t;

  // configuration registers as seen by the pipeline
  typedef struct packed {
    logic signed [38:0] base_epoch_seconds;
    logic signed [17:0] utc_offset_seconds;
    logic [31:0]        base_millisecond_count;
    logic               time_is_set;
  } cfg_regs_t;

  // word leaving the seconds-to-minutes front end
  typedef struct packed {
    logic               valid;
    logic               is_set;
    logic signed [32:0] minute_index;
    logic [24:0]        day_count;     // days since 1970 plus era-aligned bias
    logic [10:0]        minute_low;    // low bits of biased minute count
  } minutes_word_t;

  // word leaving the calendar stages
  typedef struct packed {
    logic               valid;
    logic               is_set;
    logic signed [32:0] minute_index;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic signed [17:0] year_base;     // 400 * era
    logic [8:0]         year_of_era;
    logic [8:0]         day_of_year;   // march-based
    logic [3:0]         month_index;   // 0 is march
  } civil_word_t;

  // calendar constants
  localparam logic [5:0]  SECONDS_PER_MINUTE = 6'd60;
  localparam logic [5:0]  MINUTES_PER_HOUR   = 6'd60;
  localparam logic [10:0] MINUTES_PER_DAY    = 11'd1440;
  localparam logic [17:0] DAYS_PER_ERA       = 18'd146097;
  localparam logic [17:0] LAST_DAY_OF_ERA    = 18'd146096;
  localparam logic [8:0]  DAYS_PER_YEAR      = 9'd365;
  localparam logic [8:0]  YEARS_PER_ERA      = 9'd400;
  localparam logic [3:0]  FIRST_JAN_INDEX    = 4'd10;

  // bias of 86400 * (719468 + 17 * 146097) seconds keeps the sum non-negative
  // and lines the day count up with 400-year eras
  localparam logic [39:0] DAY_BIAS_SECONDS   = 40'd276749308800;
  localparam logic [34:0] MINUTE_BIAS        = 35'd4612488480;
  localparam logic signed [17:0] ERA_YEAR_BIAS = 18'sd6800;

  // minute index clamp
  localparam logic signed [35:0] MINUTE_INDEX_MIN = -36'sd4294967296;
  localparam logic signed [35:0] MINUTE_INDEX_MAX = 36'sd4294967295;
  localparam logic signed [18:0] YEAR_MAX         = 19'sd16383;

  // reciprocals: floor(x / d) = (x * M) >> S for the stated input width
  localparam logic [29:0] RECIP_125      = 30'd549755814;   // 29-bit x, S 36
  localparam logic [19:0] RECIP_60_HI    = 20'd559241;      // 19-bit x, S 25
  localparam logic [27:0] RECIP_60_LO    = 28'd143165577;   // 27-bit x, S 33
  localparam logic [30:0] RECIP_45       = 31'd1527099484;  // 30-bit x, S 36
  localparam logic [25:0] RECIP_ERA      = 26'd60207212;    // 25-bit x, S 43
  localparam logic [11:0] RECIP_60_SMALL = 12'd2185;        // 11-bit x, S 17
  localparam logic [18:0] RECIP_1460     = 19'd367720;      // 18-bit x, S 29
  localparam logic [18:0] RECIP_36524    = 19'd470373;      // 18-bit x, S 34
  localparam logic [18:0] RECIP_365      = 19'd367720;      // 18-bit x, S 27
  localparam logic [9:0]  RECIP_100      = 10'd656;         // 9-bit x, S 16
  localparam logic [11:0] RECIP_153      = 12'd3427;        // 11-bit x, S 19

  // first march-based day of each month: (153 * mp + 2) / 5
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] start_day;
    case (mp)
      4'd0:    start_day = 9'd0;
      4'd1:    start_day = 9'd31;
      4'd2:    start_day = 9'd61;
      4'd3:    start_day = 9'd92;
      4'd4:    start_day = 9'd122;
      4'd5:    start_day = 9'd153;
      4'd6:    start_day = 9'd184;
      4'd7:    start_day = 9'd214;
      4'd8:    start_day = 9'd245;
      4'd9:    start_day = 9'd275;
      4'd10:   start_day = 9'd306;
      4'd11:   start_day = 9'd337;
      default: start_day = 9'd0;
    endcase
    return start_day;
  endfunction

endpackage

// File: rtl/core/utlc_minutes.sv
// front end: millisecond difference to local seconds, then floor minutes and days
// depends on utlc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "unix_time_to_local_civil_defines.svh"

module utlc_minutes import utlc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [31:0]   now_millis,
  input  cfg_regs_t     cfg,
  output minutes_word_t out_word
);

  // one valid bit per stage, stage 1 in bit 0
  logic [6:0] vld;
  logic [6:0] is_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    is_set <= {is_set[5:0], cfg.time_is_set};
  end

  // stage 1: counter difference and base plus offset
  logic [31:0] diff1;
  logic [39:0] base_sum1;

  always_ff @(posedge clk) begin
    diff1     <= now_millis - cfg.base_millisecond_count;
    base_sum1 <= 40'(cfg.base_epoch_seconds) + 40'(cfg.utc_offset_seconds);
  end

  // stage 2: whole seconds, divide by 8 then by 125
  logic [58:0] sec_prod;
  logic [22:0] elapsed2;
  logic [39:0] base_sum2;

  assign sec_prod = 59'(diff1[31:3]) * 59'(RECIP_125);

  always_ff @(posedge clk) begin
    elapsed2  <= sec_prod[58:36];
    base_sum2 <= base_sum1;
  end

  // stage 3: biased local seconds, always non-negative
  logic [39:0] biased3;

  always_ff @(posedge clk) begin
    biased3 <= base_sum2 + 40'(elapsed2) + DAY_BIAS_SECONDS;
  end

  // stage 4: high half over 60
  logic [38:0] hi_prod;
  logic [13:0] hi_quot4;
  logic [18:0] hi4;
  logic [20:0] lo4;

  assign hi_prod = 39'(biased3[39:21]) * 39'(RECIP_60_HI);

  always_ff @(posedge clk) begin
    hi_quot4 <= hi_prod[38:25];
    hi4      <= biased3[39:21];
    lo4      <= biased3[20:0];
  end

  // stage 5: high half remainder
  logic [18:0] hi_rem;
  logic [5:0]  hi_rem5;
  logic [13:0] hi_quot5;
  logic [20:0] lo5;

  assign hi_rem = hi4 - 19'(hi_quot4) * 19'(SECONDS_PER_MINUTE);

  always_ff @(posedge clk) begin
    hi_rem5  <= hi_rem[5:0];
    hi_quot5 <= hi_quot4;
    lo5      <= lo4;
  end

  // stage 6: remainder and low half over 60 gives the biased minute count
  logic [54:0] lo_prod;
  logic [34:0] minutes6;

  assign lo_prod = 55'({hi_rem5, lo5}) * 55'(RECIP_60_LO);

  always_ff @(posedge clk) begin
    minutes6 <= {hi_quot5, lo_prod[53:33]};
  end

  // stage 7: days by 32 then 45, clamped minute index
  logic [60:0]        day_prod;
  logic signed [35:0] minute_full;
  logic signed [35:0] minute_sat;
  logic [24:0]        days7;
  logic signed [32:0] minute_index7;
  logic [10:0]        minute_low7;

  assign day_prod    = 61'(minutes6[34:5]) * 61'(RECIP_45);
  assign minute_full = $signed({1'b0, minutes6}) - $signed({1'b0, MINUTE_BIAS});

  always_comb begin
    if (minute_full < MINUTE_INDEX_MIN) begin
      minute_sat = MINUTE_INDEX_MIN;
    end else if (minute_full > MINUTE_INDEX_MAX) begin
      minute_sat = MINUTE_INDEX_MAX;
    end else begin
      minute_sat = minute_full;
    end
  end

  always_ff @(posedge clk) begin
    days7         <= day_prod[60:36];
    minute_index7 <= 33'(minute_sat);
    minute_low7   <= minutes6[10:0];
  end

  assign out_word.valid        = vld[6];
  assign out_word.is_set       = is_set[6];
  assign out_word.minute_index = minute_index7;
  assign out_word.day_count    = days7;
  assign out_word.minute_low   = minute_low7;

  // checks
  `UTLC_ASSERT_NEXT(a_hi_rem_range, clk, rst, vld[3], hi_rem5 < SECONDS_PER_MINUTE)
  `UTLC_ASSERT_IMPL(a_day_split, clk, rst, vld[6],
    (36'(days7) * 36'(MINUTES_PER_DAY) <= 36'($past(minutes6))) &&
    (36'($past(minutes6)) - 36'(days7) * 36'(MINUTES_PER_DAY) < 36'(MINUTES_PER_DAY)))

endmodule

// File: rtl/core/utlc_civil.sv
// calendar stages: era split, year of era, day of year, month, and hour and minute
// depends on utlc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "unix_time_to_local_civil_defines.svh"

module utlc_civil import utlc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  minutes_word_t in_word,
  output civil_word_t   out_word
);

  // one valid bit per stage, stage 8 in bit 0
  logic [7:0]         vld;
  logic [7:0]         is_set;
  logic signed [32:0] minute_index [8];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[6:0], in_word.valid};
    end
  end

  always_ff @(posedge clk) begin
    is_set          <= {is_set[6:0], in_word.is_set};
    minute_index[0] <= in_word.minute_index;
    for (int i = 1; i < 8; i++) begin
      minute_index[i] <= minute_index[i-1];
    end
  end

  // stage 8: minute of day and era
  logic [35:0] day_minutes;
  logic [50:0] era_prod;
  logic [10:0] mod8;
  logic [7:0]  era8;
  logic [24:0] days8;

  assign day_minutes = 36'(in_word.day_count) * 36'(MINUTES_PER_DAY);
  assign era_prod    = 51'(in_word.day_count) * 51'(RECIP_ERA);

  always_ff @(posedge clk) begin
    mod8  <= in_word.minute_low - day_minutes[10:0];
    era8  <= era_prod[50:43];
    days8 <= in_word.day_count;
  end

  // stage 9: day of era and hour
  logic [32:0] era_days;
  logic [22:0] hour_prod;
  logic [17:0] doe9;
  logic [4:0]  hour9;
  logic [10:0] mod9;
  logic [7:0]  era9;

  assign era_days  = 33'(era8) * 33'(DAYS_PER_ERA);
  assign hour_prod = 23'(mod8) * 23'(RECIP_60_SMALL);

  always_ff @(posedge clk) begin
    doe9  <= days8[17:0] - era_days[17:0];
    hour9 <= hour_prod[21:17];
    mod9  <= mod8;
    era9  <= era8;
  end

  // stage 10: leap corrections, minute of hour, year base
  logic [36:0]        four_prod;
  logic [36:0]        cent_prod;
  logic [10:0]        hour_minutes;
  logic [10:0]        minute_full;
  logic [16:0]        era_years;
  logic [17:0]        doe10;
  logic [7:0]         four10;
  logic [2:0]         cent10;
  logic               last10;
  logic [4:0]         hour10;
  logic [5:0]         minute10;
  logic signed [17:0] year_base10;

  assign four_prod    = 37'(doe9) * 37'(RECIP_1460);
  assign cent_prod    = 37'(doe9) * 37'(RECIP_36524);
  assign hour_minutes = 11'(hour9) * 11'(MINUTES_PER_HOUR);
  assign minute_full  = mod9 - hour_minutes;
  assign era_years    = 17'(era9) * 17'(YEARS_PER_ERA);

  always_ff @(posedge clk) begin
    doe10       <= doe9;
    four10      <= four_prod[36:29];
    cent10      <= cent_prod[36:34];
    last10      <= (doe9 == LAST_DAY_OF_ERA);
    hour10      <= hour9;
    minute10    <= minute_full[5:0];
    year_base10 <= $signed({1'b0, era_years}) - ERA_YEAR_BIAS;
  end

  // hour, minute and year base ride along to the end
  logic [4:0]         hour_d [5];
  logic [5:0]         minute_d [5];
  logic signed [17:0] year_base_d [5];

  always_ff @(posedge clk) begin
    hour_d[0]      <= hour10;
    minute_d[0]    <= minute10;
    year_base_d[0] <= year_base10;
    for (int i = 1; i < 5; i++) begin
      hour_d[i]      <= hour_d[i-1];
      minute_d[i]    <= minute_d[i-1];
      year_base_d[i] <= year_base_d[i-1];
    end
  end

  // stage 11: days adjusted to a 365-day year
  logic [17:0] adj11;
  logic [17:0] doe11;

  always_ff @(posedge clk) begin
    adj11 <= doe10 - 18'(four10) + 18'(cent10) - 18'(last10);
    doe11 <= doe10;
  end

  // stage 12: year of era
  logic [36:0] year_prod;
  logic [8:0]  yoe12;
  logic [17:0] doe12;

  assign year_prod = 37'(adj11) * 37'(RECIP_365);

  always_ff @(posedge clk) begin
    yoe12 <= year_prod[35:27];
    doe12 <= doe11;
  end

  // stage 13: days before this year of era
  logic [18:0] yc_prod;
  logic [17:0] prior13;
  logic [1:0]  centuries13;
  logic [8:0]  yoe13;
  logic [17:0] doe13;

  assign yc_prod = 19'(yoe12) * 19'(RECIP_100);

  always_ff @(posedge clk) begin
    prior13     <= 18'(yoe12) * 18'(DAYS_PER_YEAR) + 18'(yoe12[8:2]);
    centuries13 <= yc_prod[17:16];
    yoe13       <= yoe12;
    doe13       <= doe12;
  end

  // stage 14: day of year
  logic [17:0] doy_full;
  logic [8:0]  doy14;
  logic [8:0]  yoe14;

  assign doy_full = doe13 - prior13 + 18'(centuries13);

  always_ff @(posedge clk) begin
    doy14 <= doy_full[8:0];
    yoe14 <= yoe13;
  end

  // stage 15: march-based month
  logic [10:0] month_arg;
  logic [22:0] month_prod;
  logic [3:0]  mp15;
  logic [8:0]  doy15;
  logic [8:0]  yoe15;

  assign month_arg  = 11'(doy14) * 11'd5 + 11'd2;
  assign month_prod = 23'(month_arg) * 23'(RECIP_153);

  always_ff @(posedge clk) begin
    mp15  <= month_prod[22:19];
    doy15 <= doy14;
    yoe15 <= yoe14;
  end

  assign out_word.valid        = vld[7];
  assign out_word.is_set       = is_set[7];
  assign out_word.minute_index = minute_index[7];
  assign out_word.hour         = hour_d[4];
  assign out_word.minute       = minute_d[4];
  assign out_word.year_base    = year_base_d[4];
  assign out_word.year_of_era  = yoe15;
  assign out_word.day_of_year  = doy15;
  assign out_word.month_index  = mp15;

  // checks
  `UTLC_ASSERT_IMPL(a_doe_range, clk, rst, vld[1], doe9 < DAYS_PER_ERA)
  `UTLC_ASSERT_IMPL(a_year_split, clk, rst, vld[4],
    (yoe12 < YEARS_PER_ERA) && (37'(yoe12) * 37'(DAYS_PER_YEAR) <= 37'($past(adj11))))

endmodule

// File: rtl/core/unix_time_to_local_civil.sv
// channel   | handshake        | payload
// input     | start / busy     | now_millis
// result    | done (strobe)    | time_valid, minute_index, hour_of_day, minute_of_hour,
//           |                  | civil_year, civil_month, day_of_month
// config    | cfg_write        | cfg_index, cfg_data
//
// one word is taken every cycle while busy is low; its result shows on done once it has passed
// utlc_minutes, utlc_civil and the result register, a chain of reciprocal multipliers (seconds,
// minutes, days, era, year, month), each followed by a register
// rst is synchronous: it clears the pipeline valid bits and the configuration
// registers, and busy is high while rst is high
// the receiver has no back-pressure, so the pipeline advances on every clock
// depends on utlc_pkg, utlc_minutes, utlc_civil and the assertion macro header
`timescale 1ns / 1ps
`include "unix_time_to_local_civil_defines.svh"

module unix_time_to_local_civil import utlc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        now_millis,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [38:0]        cfg_data,
  output logic               done,
  output logic               time_valid,
  output logic signed [32:0] minute_index,
  output logic [4:0]         hour_of_day,
  output logic [5:0]         minute_of_hour,
  output logic [13:0]        civil_year,
  output logic [3:0]         civil_month,
  output logic [4:0]         day_of_month
);

  localparam int unsigned LATENCY = 16;

  cfg_regs_t     cfg;
  minutes_word_t min_word;
  civil_word_t   civ_word;
  logic          accept;

  assign busy   = rst;
  assign accept = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BASE_EPOCH:  cfg.base_epoch_seconds     <= $signed(cfg_data);
        REG_UTC_OFFSET:  cfg.utc_offset_seconds     <= $signed(cfg_data[17:0]);
        REG_BASE_MILLIS: cfg.base_millisecond_count <= cfg_data[31:0];
        REG_TIME_SET:    cfg.time_is_set            <= cfg_data[0];
      endcase
    end
  end

  // seconds to minutes and days
  utlc_minutes u_minutes (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (accept),
    .now_millis (now_millis),
    .cfg        (cfg),
    .out_word   (min_word)
  );

  // calendar and time of day
  utlc_civil u_civil (
    .clk      (clk),
    .rst      (rst),
    .in_word  (min_word),
    .out_word (civ_word)
  );

  // final stage: day, month, clamped year
  logic [8:0]         day_full;
  logic [3:0]         month_num;
  logic               jan_feb;
  logic signed [18:0] year_full;
  logic [13:0]        year_sat;

  assign day_full  = civ_word.day_of_year - month_start(civ_word.month_index) + 9'd1;
  assign jan_feb   = (civ_word.month_index >= FIRST_JAN_INDEX);
  assign month_num = jan_feb ? civ_word.month_index - 4'd9 : civ_word.month_index + 4'd3;
  assign year_full = 19'(civ_word.year_base) + $signed({10'b0, civ_word.year_of_era})
                     + $signed({18'b0, jan_feb});

  always_comb begin
    if (year_full < 19'sd0) begin
      year_sat = '0;
    end else if (year_full > YEAR_MAX) begin
      year_sat = '1;
    end else begin
      year_sat = year_full[13:0];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= civ_word.valid;
    end
  end

  // result word, forced when the clock is not set
  always_ff @(posedge clk) begin
    time_valid <= civ_word.is_set;
    if (civ_word.is_set) begin
      minute_index   <= civ_word.minute_index;
      hour_of_day    <= civ_word.hour;
      minute_of_hour <= civ_word.minute;
      civil_year     <= year_sat;
      civil_month    <= month_num;
      day_of_month   <= day_full[4:0];
    end else begin
      minute_index   <= '1;
      hour_of_day    <= '0;
      minute_of_hour <= '0;
      civil_year     <= '0;
      civil_month    <= '0;
      day_of_month   <= '0;
    end
  end

  // checks
  `UTLC_ASSERT_IMPL(a_done_latency, clk, rst, done, $past(accept, LATENCY))
  `UTLC_ASSERT_IMPL(a_fields_range, clk, rst, done && time_valid,
    (hour_of_day < 5'd24) && (minute_of_hour < 6'd60) && (civil_month != 4'd0) &&
    (civil_month < 4'd13) && (day_of_month != 5'd0))

endmodule

// File: verif/tb_top.sv
// self-checking bench for unix_time_to_local_civil: millisecond samples in, local civil time out
// drives words and register writes from a planned queue and checks each result against a predictor
// depends on utlc_pkg for the register index codes; needs only the rtl of the block
`timescale 1ns / 1ps

module tb_top;
  import utlc_pkg::*;

  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 24;    // longer than the pipeline latency
  localparam int STALL_LIMIT  = 2000;
  localparam int RANDOM_PHASES = 16;
  localparam int WORDS_PER_PHASE = 100;
  localparam int PRINT_LIMIT = 40;

  typedef enum logic {ENTRY_WORD, ENTRY_REG} entry_kind_t;

  typedef struct {
    entry_kind_t kind;
    logic [31:0] millis;
    cfg_reg_t    reg_index;
    logic [38:0] reg_data;
    int          gap_after;
  } plan_entry_t;

  typedef struct packed {
    logic               time_valid;
    logic signed [32:0] minute_index;
    logic [4:0]         hour_of_day;
    logic [5:0]         minute_of_hour;
    logic [13:0]        civil_year;
    logic [3:0]         civil_month;
    logic [4:0]         day_of_month;
  } civil_time_t;

  typedef struct {
    logic [31:0] millis;
    civil_time_t civil;
  } civil_due_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [31:0]        now_millis = '0;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [38:0]        cfg_data = '0;
  logic               done;
  logic               time_valid;
  logic signed [32:0] minute_index;
  logic [4:0]         hour_of_day;
  logic [5:0]         minute_of_hour;
  logic [13:0]        civil_year;
  logic [3:0]         civil_month;
  logic [4:0]         day_of_month;

  // planned stimulus and predicted results
  plan_entry_t millis_plan[$];
  civil_due_t  civil_due[$];
  logic [31:0] plan_ms = '0;

  // predictor copy of the clock registers
  longint      set_epoch = 0;
  longint      set_offset = 0;
  logic [31:0] set_millis = '0;
  logic        set_flag = 1'b0;

  int words_in_flight = 0;
  int idle_left = 0;
  int mismatch_count = 0;
  int stall_cycles = 0;

  unix_time_to_local_civil dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .now_millis     (now_millis),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .done           (done),
    .time_valid     (time_valid),
    .minute_index   (minute_index),
    .hour_of_day    (hour_of_day),
    .minute_of_hour (minute_of_hour),
    .civil_year     (civil_year),
    .civil_month    (civil_month),
    .day_of_month   (day_of_month)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // floor division by a positive divisor
  function automatic longint floor_quot(input longint a, input longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  // local civil time of one millisecond sample under the current registers
  function automatic civil_time_t civil_from_millis(input logic [31:0] now);
    civil_time_t r;
    logic [31:0] elapsed_ms;
    longint secs, mins, days, day_secs, z, era, doe, yoe, doy, mp, dom, mon, yr;
    r = '0;
    if (!set_flag) begin
      r.minute_index = '1;
      return r;
    end
    elapsed_ms = now - set_millis;
    secs = set_epoch + set_offset + longint'({32'd0, elapsed_ms / 32'd1000});
    mins = floor_quot(secs, 60);
    if (mins < -64'sd4294967296) mins = -64'sd4294967296;
    if (mins > 64'sd4294967295) mins = 64'sd4294967295;
    days = floor_quot(secs, 86400);
    day_secs = secs - days * 86400;
    // days-to-civil over march-based years of 400-year eras
    z = days + 719468;
    era = floor_quot(z, 146097);
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    dom = doy - (153 * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    yr = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    if (yr < 0) yr = 0;
    if (yr > 16383) yr = 16383;
    r.time_valid = 1'b1;
    r.minute_index = mins[32:0];
    r.hour_of_day = 5'(day_secs / 3600);
    r.minute_of_hour = 6'((day_secs / 60) % 60);
    r.civil_year = yr[13:0];
    r.civil_month = mon[3:0];
    r.day_of_month = dom[4:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want, input logic [31:0] millis);
    if (got !== want)
      report_mismatch($sformatf("%s for now_millis 0x%08h: got 0x%0h, want 0x%0h",
                                name, millis, got, want));
  endtask

  // queue one register write, with junk above the register width
  task automatic plan_reg(input cfg_reg_t idx, input logic [38:0] value);
    plan_entry_t e;
    logic [63:0] junk;
    logic [38:0] mask;
    int width;
    junk = {$urandom, $urandom};
    case (idx)
      REG_BASE_EPOCH:  width = 39;
      REG_UTC_OFFSET:  width = 18;
      REG_BASE_MILLIS: width = 32;
      default:         width = 1;
    endcase
    mask = (39'd1 << width) - 39'd1;
    e.kind = ENTRY_REG;
    e.millis = '0;
    e.reg_index = idx;
    e.reg_data = (junk[38:0] & ~mask) | (value & mask);
    e.gap_after = 0;
    millis_plan.push_back(e);
    if (idx == REG_BASE_MILLIS) plan_ms = value[31:0];
  endtask

  task automatic plan_config(input longint epoch, input longint offset,
                             input logic [31:0] ms, input logic flag);
    plan_reg(REG_BASE_EPOCH, epoch[38:0]);
    plan_reg(REG_UTC_OFFSET, offset[38:0]);
    plan_reg(REG_BASE_MILLIS, {7'd0, ms});
    plan_reg(REG_TIME_SET, {38'd0, flag});
  endtask

  task automatic plan_word(input logic [31:0] millis, input int gap);
    plan_entry_t e;
    e.kind = ENTRY_WORD;
    e.millis = millis;
    e.reg_index = REG_BASE_EPOCH;
    e.reg_data = '0;
    e.gap_after = gap;
    millis_plan.push_back(e);
  endtask

  // idle cycles after a word: none in mode 0, else a mix of none, short and long, more short in mode 2
  function automatic int pick_gap(input int mode);
    int r;
    if (mode == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 60 - 20 * (mode - 1)) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver: offers planned words, writes registers only once the pipeline is empty
  always @(posedge clk) begin : drive
    logic offer;
    logic issue_reg;
    plan_entry_t head;
    if (rst) begin
      start <= 1'b0;
      cfg_write <= 1'b0;
    end else begin
      offer = start;
      issue_reg = 1'b0;
      if (start && !busy) begin
        words_in_flight++;
        offer = 1'b0;
      end
      if (done && words_in_flight > 0) words_in_flight--;
      if (!offer) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (millis_plan.size() > 0) begin
          head = millis_plan[0];
          if (head.kind == ENTRY_WORD) begin
            head = millis_plan.pop_front();
            offer = 1'b1;
            now_millis <= head.millis;
            idle_left = head.gap_after;
          end else if (words_in_flight == 0) begin
            head = millis_plan.pop_front();
            issue_reg = 1'b1;
            cfg_index <= head.reg_index;
            cfg_data <= head.reg_data;
          end
        end
      end
      start <= offer;
      cfg_write <= issue_reg;
    end
  end

  // monitor: tracks register writes, predicts accepted words, checks results
  always @(posedge clk) begin : observe
    civil_due_t due;
    if (!rst) begin
      if (cfg_write) begin
        case (cfg_index)
          REG_BASE_EPOCH:  set_epoch = longint'(signed'(cfg_data));
          REG_UTC_OFFSET:  set_offset = longint'(signed'(cfg_data[17:0]));
          REG_BASE_MILLIS: set_millis = cfg_data[31:0];
          REG_TIME_SET:    set_flag = cfg_data[0];
          default: ;
        endcase
      end
      if (done) begin
        if (civil_due.size() == 0) begin
          report_mismatch($sformatf("result with no word pending, minute index 0x%0h",
                                    minute_index));
        end else begin
          due = civil_due.pop_front();
          compare_field("time_valid", 64'(time_valid), 64'(due.civil.time_valid), due.millis);
          compare_field("minute_index", 64'(minute_index), 64'(due.civil.minute_index),
                        due.millis);
          compare_field("hour_of_day", 64'(hour_of_day), 64'(due.civil.hour_of_day),
                        due.millis);
          compare_field("minute_of_hour", 64'(minute_of_hour),
                        64'(due.civil.minute_of_hour), due.millis);
          compare_field("civil_year", 64'(civil_year), 64'(due.civil.civil_year), due.millis);
          compare_field("civil_month", 64'(civil_month), 64'(due.civil.civil_month),
                        due.millis);
          compare_field("day_of_month", 64'(day_of_month), 64'(due.civil.day_of_month),
                        due.millis);
        end
      end
      if (start && !busy) begin
        due.millis = now_millis;
        due.civil = civil_from_millis(now_millis);
        civil_due.push_back(due);
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin : watchdog
    if (rst || (start && !busy) || done || cfg_write) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus plan, reset and end of run
  initial begin : stimulus
    longint epoch, offset, day;
    logic [31:0] ms, millis;
    logic [63:0] r;
    logic flag;
    int phase, n, pick, gap_mode;

    // clock not set, registers at reset
    plan_word(32'h0000_0000, pick_gap(1));
    plan_word(32'hFFFF_FFFF, pick_gap(1));
    // registers loaded but flag still clear
    plan_reg(REG_BASE_EPOCH, 39'd123456789);
    plan_word($urandom, pick_gap(1));
    // epoch start, minute and day edges, largest sample
    plan_config(0, 0, 32'd0, 1'b1);
    plan_word(32'd0, 0);
    plan_word(32'd59999, 0);
    plan_word(32'd60000, pick_gap(1));
    plan_word(32'd86399999, 0);
    plan_word(32'hFFFF_FFFF, pick_gap(1));
    // counter wrapped after setting
    plan_reg(REG_BASE_MILLIS, 39'h0_FFFF_FF00);
    plan_word(32'h0000_0010, 0);
    plan_word(32'hFFFF_FEFF, 0);
    // one second before the epoch, floor toward the past
    plan_config(-1, 0, 32'd0, 1'b1);
    plan_word(32'd0, 0);
    plan_word(32'd1000, pick_gap(1));
    // offset extremes
    plan_config(0, -86400, 32'd0, 1'b1);
    plan_word(32'd0, 0);
    plan_reg(REG_UTC_OFFSET, 39'd86400);
    plan_word(32'd0, 0);
    // first and last day of the stated epoch range
    plan_config(-64'sd62135596800, -86400, 32'd0, 1'b1);
    plan_word(32'd0, 0);
    plan_config(64'sd253402300799, 86400, 32'd0, 1'b1);
    plan_word(32'd0, 0);
    // leap day of a 400-year year, and february end of a century year
    plan_config(64'sd951782399, 0, 32'd1000, 1'b1);
    plan_word(32'd1000, 0);
    plan_word(32'd2000, 0);
    plan_reg(REG_BASE_EPOCH, 39'(-64'sd2203891201));
    plan_word(32'd1000, pick_gap(1));
    // registers past their ranges: minute index saturates, year clamps at zero
    plan_config(-64'sd274877906944, -131072, 32'd0, 1'b1);
    plan_word(32'd0, 0);
    plan_config(64'sd274877906943, 131071, 32'd0, 1'b1);
    plan_word(32'hFFFF_FFFF, 0);
    // flag cleared with loaded registers
    plan_reg(REG_TIME_SET, 39'd0);
    plan_word($urandom, pick_gap(1));

    // random phases, each under its own register setting
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      gap_mode = $urandom_range(0, 2);
      r = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        epoch = longint'(signed'(r[38:0]));
      end else if (pick < 35) begin
        day = longint'($urandom_range(0, 3652058)) - 719162;
        epoch = day * 86400 - longint'($urandom_range(0, 7200));
      end else begin
        epoch = -64'sd62135596800 + longint'(r % 64'd315537897600);
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) offset = longint'(signed'(18'($urandom)));
      else if (pick < 30) offset = (longint'($urandom_range(0, 192)) - 96) * 900;
      else offset = longint'($urandom_range(0, 172800)) - 86400;
      ms = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 100000) : $urandom;
      flag = ($urandom_range(0, 99) < 85);
      if (phase == 0 || $urandom_range(0, 3) != 0) begin
        plan_config(epoch, offset, ms, flag);
      end else begin
        // partial rewrite, the rest keep their values
        if ($urandom_range(0, 1)) plan_reg(REG_BASE_EPOCH, epoch[38:0]);
        if ($urandom_range(0, 1)) plan_reg(REG_UTC_OFFSET, offset[38:0]);
        if ($urandom_range(0, 1)) plan_reg(REG_BASE_MILLIS, {7'd0, ms});
        plan_reg(REG_TIME_SET, {38'd0, flag});
      end
      for (n = 0; n < WORDS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 20)
          millis = $urandom;
        else if (pick < 55)
          millis = plan_ms + $urandom_range(0, 3600000);
        else if (pick < 70)
          millis = plan_ms + $urandom_range(0, 1440) * 32'd60000 - $urandom_range(0, 1500);
        else if (pick < 85)
          millis = plan_ms - $urandom_range(1, 100000);
        else
          millis = plan_ms + $urandom_range(0, 48) * 32'd86400000 - $urandom_range(0, 60000);
        plan_word(millis, pick_gap(gap_mode));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // drain: everything issued, every result in, then a few more cycles
    while (millis_plan.size() != 0 || start || cfg_write || words_in_flight != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (civil_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", civil_due.size()));

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/utlc_pkg.sv
rtl/core/utlc_minutes.sv
rtl/core/utlc_civil.sv
rtl/core/unix_time_to_local_civil.sv
verif/tb_top.sv
